@@ rtl/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared sizes, types and command codes of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Space geometry
    localparam int SPACE_LOG2  = 16;
    localparam int MIN_SHIFT   = 5;   // 32-byte minimum block
    localparam int ALIGN_SHIFT = 4;   // 16-byte rounding and header
    localparam int SLOT_W      = SPACE_LOG2 - MIN_SHIFT;
    localparam int LINK_W      = SLOT_W + 1;
    localparam int NSLOTS      = 1 << SLOT_W;
    localparam int NLEVELS     = SLOT_W + 1;
    localparam int LVL_W       = 4;
    localparam int NEED_W      = SPACE_LOG2 + 2;

    localparam logic [LINK_W-1:0] NIL      = LINK_W'(NSLOTS);
    localparam logic [LVL_W-1:0]  LAST_LVL = LVL_W'(NLEVELS - 1);
    localparam logic [NEED_W-1:0] SPACE_BYTES = NEED_W'(1) << SPACE_LOG2;
    localparam logic [NEED_W-1:0] ALIGN_BYTES = NEED_W'(1) << ALIGN_SHIFT;

    // Per-slot bookkeeping word
    typedef struct packed {
        logic [LVL_W-1:0] lvl;
        logic             free;
        logic             used;
    } t_meta;

    // Datapath commands
    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CLR,
        CMD_LOAD,
        CMD_A_RD,
        CMD_A_POP,
        CMD_A_SPLIT,
        CMD_F_RD,
        CMD_F_CHK,
        CMD_M_RD,
        CMD_M_CHK,
        CMD_PUSH1,
        CMD_PUSH2,
        CMD_FIN_OK,
        CMD_FIN_FAIL
    } t_cmd_code;

    typedef struct packed {
        t_cmd_code code;
    } t_dp_cmd;

    typedef struct packed {
        logic op_free;     // latched op is free
        logic ld_fail;     // item at the inputs fails at once
        logic clr_last;    // clearing pass at last slot
        logic at_target;   // alloc level reached target
        logic split_last;  // next split reaches target
        logic meta_used;   // freed slot is granted
        logic meta_lvl0;   // freed slot sits at level zero
        logic merge_ok;    // buddy free at same level
        logic lv_one;      // current merge level is one
    } t_dp_stat;

endpackage

@@ rtl/bba_ctrl.sv @@
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: clearing pass, allocate split walk, free merge walk, result.
// ----------------------------------------------------------------------------
module bba_ctrl import bba_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_op,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy,
    output logic     o_valid
);

    typedef enum logic [11:0] {
        S_CLEAR   = 12'b000000000001,
        S_IDLE    = 12'b000000000010,
        S_A_RD    = 12'b000000000100,
        S_A_POP   = 12'b000000001000,
        S_A_SPLIT = 12'b000000010000,
        S_F_RD    = 12'b000000100000,
        S_F_CHK   = 12'b000001000000,
        S_M_RD    = 12'b000010000000,
        S_M_CHK   = 12'b000100000000,
        S_PUSH1   = 12'b001000000000,
        S_PUSH2   = 12'b010000000000,
        S_FIN     = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic   r_fail, n_fail;
    logic   r_done, n_done;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_fail  <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_fail  <= n_fail;
            r_done  <= n_done;
        end
    end

    // Next state and command
    always_comb begin
        n_state    = r_state;
        n_fail     = r_fail;
        n_done     = 1'b0;
        o_cmd.code = CMD_NOP;
        case (r_state)
            S_CLEAR: begin
                o_cmd.code = CMD_CLR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (start && !r_done) begin
                    o_cmd.code = CMD_LOAD;
                    n_fail     = i_stat.ld_fail;
                    if (i_stat.ld_fail) n_state = S_FIN;
                    else if (i_op)      n_state = S_F_RD;
                    else                n_state = S_A_RD;
                end
            end
            S_A_RD: begin
                o_cmd.code = CMD_A_RD;
                n_state    = S_A_POP;
            end
            S_A_POP: begin
                o_cmd.code = CMD_A_POP;
                n_state    = i_stat.at_target ? S_FIN : S_A_SPLIT;
            end
            S_A_SPLIT: begin
                o_cmd.code = CMD_A_SPLIT;
                if (i_stat.split_last) n_state = S_FIN;
            end
            S_F_RD: begin
                o_cmd.code = CMD_F_RD;
                n_state    = S_F_CHK;
            end
            S_F_CHK: begin
                o_cmd.code = CMD_F_CHK;
                if (!i_stat.meta_used) begin
                    n_fail  = 1'b1;
                    n_state = S_FIN;
                end else if (i_stat.meta_lvl0) begin
                    n_state = S_PUSH1;
                end else begin
                    n_state = S_M_RD;
                end
            end
            S_M_RD: begin
                o_cmd.code = CMD_M_RD;
                n_state    = S_M_CHK;
            end
            S_M_CHK: begin
                o_cmd.code = CMD_M_CHK;
                if (!i_stat.merge_ok || i_stat.lv_one) n_state = S_PUSH1;
                else                                   n_state = S_M_RD;
            end
            S_PUSH1: begin
                o_cmd.code = CMD_PUSH1;
                n_state    = S_PUSH2;
            end
            S_PUSH2: begin
                o_cmd.code = CMD_PUSH2;
                n_state    = S_FIN;
            end
            S_FIN: begin
                o_cmd.code = r_fail ? CMD_FIN_FAIL : CMD_FIN_OK;
                n_done     = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Result strobe lines up with the result registers
    assign o_valid = r_done;
    assign busy    = (r_state != S_IDLE) || r_done;

    a_strobe_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid) else $error("result strobe longer than one cycle");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted item did not raise busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_IDLE)) else $error("result shown while working");

endmodule

@@ rtl/bba_dp.sv @@
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: free list heads, link and slot memories, result registers.
// ----------------------------------------------------------------------------
module bba_dp import bba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dp_cmd     i_cmd,
    input  logic        i_op,
    input  logic [15:0] i_req_bytes,
    input  logic [15:0] i_free_offset,
    output t_dp_stat    o_stat,
    output logic        o_ok,
    output logic [15:0] o_payload_offset,
    output logic [3:0]  o_granted_level
);

    // Memories
    logic [LINK_W-1:0] next_mem [NSLOTS];
    logic [LINK_W-1:0] prev_mem [NSLOTS];
    t_meta             meta_mem [NSLOTS];

    logic [LINK_W-1:0] r_head [NLEVELS];
    logic [LINK_W-1:0] r_next_rd, r_prev_rd;
    t_meta             r_meta_rd;

    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SLOT_W-1:0] r_buddy, n_buddy;
    logic [LVL_W-1:0]  r_lv, n_lv;
    logic [LVL_W-1:0]  r_idx, n_idx;
    logic [LVL_W-1:0]  r_flv, n_flv;
    logic [LINK_W-1:0] r_hold, n_hold;
    logic [SLOT_W-1:0] r_clr;
    logic              r_op;

    logic              next_we, prev_we, meta_we, head_we;
    logic [SLOT_W-1:0] next_wa, prev_wa, meta_wa, rd_a;
    logic [LINK_W-1:0] next_wd, prev_wd, head_wd;
    t_meta             meta_wd;
    logic [LVL_W-1:0]  head_wi;

    // Load-time decode
    logic [NEED_W-1:0] needed;
    logic              too_big, found, free_bad;
    logic [LVL_W-1:0]  ld_idx, ld_cur;
    logic [15:0]       fstart;
    logic [LVL_W-1:0]  split_lv;
    logic [SLOT_W-1:0] split_slot, buddy_slot;

    always_comb begin
        needed  = ((NEED_W'(i_req_bytes) + ALIGN_BYTES - NEED_W'(1))
                   & ~(ALIGN_BYTES - NEED_W'(1))) + ALIGN_BYTES;
        too_big = needed > SPACE_BYTES;
        ld_idx  = '0;
        for (int lv = 0; lv < NLEVELS; lv++) begin
            if ((SPACE_BYTES >> lv) >= needed) ld_idx = LVL_W'(lv);
        end
        found  = 1'b0;
        ld_cur = '0;
        for (int lv = 0; lv < NLEVELS; lv++) begin
            if (LVL_W'(lv) <= ld_idx && !r_head[lv][LINK_W-1]) begin
                found  = 1'b1;
                ld_cur = LVL_W'(lv);
            end
        end
        fstart   = i_free_offset - 16'(ALIGN_BYTES);
        free_bad = (i_free_offset < 16'(ALIGN_BYTES))
                   || (fstart[MIN_SHIFT-1:0] != '0);
    end

    assign split_lv   = r_lv + LVL_W'(1);
    assign split_slot = r_slot | (SLOT_W'(1) << (LAST_LVL - split_lv));
    assign buddy_slot = r_slot ^ (SLOT_W'(1) << (LAST_LVL - r_lv));

    // Status toward the sequencer
    always_comb begin
        o_stat.op_free    = r_op;
        o_stat.ld_fail    = i_op ? free_bad : (too_big || !found);
        o_stat.clr_last   = (r_clr == {SLOT_W{1'b1}});
        o_stat.at_target  = (r_lv == r_idx);
        o_stat.split_last = (split_lv == r_idx);
        o_stat.meta_used  = r_meta_rd.used;
        o_stat.meta_lvl0  = (r_meta_rd.lvl == '0);
        o_stat.merge_ok   = r_meta_rd.free && (r_meta_rd.lvl == r_lv);
        o_stat.lv_one     = (r_lv == LVL_W'(1));
    end

    // Command decode
    always_comb begin
        next_we = 1'b0; next_wa = r_slot; next_wd = NIL;
        prev_we = 1'b0; prev_wa = r_slot; prev_wd = NIL;
        meta_we = 1'b0; meta_wa = r_slot; meta_wd = '0;
        head_we = 1'b0; head_wi = r_lv;   head_wd = NIL;
        rd_a    = r_slot;
        n_slot  = r_slot;
        n_buddy = r_buddy;
        n_lv    = r_lv;
        n_idx   = r_idx;
        n_flv   = r_flv;
        n_hold  = r_hold;
        case (i_cmd.code)
            CMD_CLR: begin
                // empty links and clean slot word, slot zero free
                next_we = 1'b1;
                next_wa = r_clr;
                prev_we = 1'b1;
                prev_wa = r_clr;
                meta_we = 1'b1;
                meta_wa = r_clr;
                meta_wd.free = (r_clr == '0);
            end
            CMD_LOAD: begin
                n_slot = fstart[MIN_SHIFT +: SLOT_W];
                n_lv   = i_op ? '0 : ld_cur;
                n_idx  = ld_idx;
                n_flv  = '0;
            end
            CMD_A_RD: begin
                n_slot = r_head[r_lv][SLOT_W-1:0];
                rd_a   = r_head[r_lv][SLOT_W-1:0];
            end
            CMD_A_POP: begin
                // unlink head, mark the granted slot
                head_we = 1'b1;
                head_wd = r_next_rd;
                prev_we = !r_next_rd[LINK_W-1];
                prev_wa = r_next_rd[SLOT_W-1:0];
                meta_we = 1'b1;
                meta_wd = '{lvl: r_idx, free: 1'b0, used: 1'b1};
            end
            CMD_A_SPLIT: begin
                // right half goes alone onto the empty deeper list
                next_we = 1'b1; next_wa = split_slot;
                prev_we = 1'b1; prev_wa = split_slot;
                meta_we = 1'b1; meta_wa = split_slot;
                meta_wd = '{lvl: split_lv, free: 1'b1, used: 1'b0};
                head_we = 1'b1; head_wi = split_lv;
                head_wd = {1'b0, split_slot};
                n_lv    = split_lv;
            end
            CMD_F_RD: begin
                rd_a = r_slot;
            end
            CMD_F_CHK: begin
                if (r_meta_rd.used) begin
                    meta_we = 1'b1;
                    n_lv    = r_meta_rd.lvl;
                    n_flv   = r_meta_rd.lvl;
                end
            end
            CMD_M_RD: begin
                rd_a    = buddy_slot;
                n_buddy = buddy_slot;
            end
            CMD_M_CHK: begin
                if (o_stat.merge_ok) begin
                    next_we = !r_prev_rd[LINK_W-1];
                    next_wa = r_prev_rd[SLOT_W-1:0];
                    next_wd = r_next_rd;
                    head_we = r_prev_rd[LINK_W-1];
                    head_wd = r_next_rd;
                    prev_we = !r_next_rd[LINK_W-1];
                    prev_wa = r_next_rd[SLOT_W-1:0];
                    prev_wd = r_prev_rd;
                    meta_we = 1'b1;
                    meta_wa = r_buddy;
                    n_slot  = (r_buddy < r_slot) ? r_buddy : r_slot;
                    n_lv    = r_lv - LVL_W'(1);
                end
            end
            CMD_PUSH1: begin
                next_we = 1'b1; next_wd = r_head[r_lv];
                prev_we = 1'b1;
                meta_we = 1'b1;
                meta_wd = '{lvl: r_lv, free: 1'b1, used: 1'b0};
                head_we = 1'b1; head_wd = {1'b0, r_slot};
                n_hold  = r_head[r_lv];
            end
            CMD_PUSH2: begin
                prev_we = !r_hold[LINK_W-1];
                prev_wa = r_hold[SLOT_W-1:0];
                prev_wd = {1'b0, r_slot};
            end
            default: begin
            end
        endcase
    end

    // Memory ports
    always_ff @(posedge i_clk) begin
        if (next_we) next_mem[next_wa] <= next_wd;
        r_next_rd <= next_mem[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (prev_we) prev_mem[prev_wa] <= prev_wd;
        r_prev_rd <= prev_mem[rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (meta_we) meta_mem[meta_wa] <= meta_wd;
        r_meta_rd <= meta_mem[rd_a];
    end

    // List heads and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int lv = 0; lv < NLEVELS; lv++) begin
                r_head[lv] <= (lv == 0) ? '0 : NIL;
            end
            r_clr <= '0;
        end else begin
            if (head_we) r_head[head_wi] <= head_wd;
            if (i_cmd.code == CMD_CLR) r_clr <= r_clr + SLOT_W'(1);
        end
    end

    // Working registers
    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_buddy <= n_buddy;
        r_lv    <= n_lv;
        r_idx   <= n_idx;
        r_flv   <= n_flv;
        r_hold  <= n_hold;
        if (i_cmd.code == CMD_LOAD) r_op <= i_op;
    end

    // Result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_ok             <= 1'b0;
            o_payload_offset <= '0;
            o_granted_level  <= '0;
        end else if (i_cmd.code == CMD_FIN_OK) begin
            o_ok             <= 1'b1;
            o_payload_offset <= r_op ? '0
                              : ({r_slot, MIN_SHIFT'(0)} + 16'(ALIGN_BYTES));
            o_granted_level  <= r_op ? r_flv : r_idx;
        end else if (i_cmd.code == CMD_FIN_FAIL) begin
            o_ok             <= 1'b0;
            o_payload_offset <= '0;
            o_granted_level  <= '0;
        end
    end

    a_split_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == CMD_A_SPLIT) |-> (r_lv < r_idx))
        else $error("split past target level");
    a_merge_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == CMD_M_RD) |-> (r_lv != '0))
        else $error("merge attempted at whole space");
    a_push_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.code == CMD_PUSH1) |=> (r_head[$past(r_lv)] == {1'b0, $past(r_slot)}))
        else $error("pushed slot is not list head");

endmodule

@@ rtl/buddy_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Binary buddy allocator, 64 KiB space, 32-byte blocks, 12 levels.
// ----------------------------------------------------------------------------
// An allocate walks its split steps and a free its merge steps before the result;
// a request too large, no free block or a bad offset fails at load, and a block
// that is not granted fails once its slot word has been read.
// One item at a time; the result strobe lasts one cycle, no stall.
// After reset a clearing pass runs over all 2048 slots of the slot and link
// tables, with busy high.
module buddy_block_allocator_unit import bba_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_op,
    input  logic [15:0] i_req_bytes,
    input  logic [15:0] i_free_offset,
    output logic        o_valid,
    output logic        o_ok,
    output logic [15:0] o_payload_offset,
    output logic [3:0]  o_granted_level
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_op    (i_op),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_valid (o_valid)
    );

    bba_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_op             (i_op),
        .i_req_bytes      (i_req_bytes),
        .i_free_offset    (i_free_offset),
        .o_stat           (stat),
        .o_ok             (o_ok),
        .o_payload_offset (o_payload_offset),
        .o_granted_level  (o_granted_level)
    );

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the buddy block allocator: directed and random
// allocate/free commands, results predicted by a behavioral allocator model.
// ----------------------------------------------------------------------------
module tb;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;
    localparam int   SLOTS    = 2048;
    localparam int   LEVELS   = 12;
    localparam int   SLOT_NIL = 2048;

    typedef struct {
        logic        op;
        logic [15:0] req_bytes;
        logic [15:0] free_offset;
        bit          sync;      // hold off until all results are back
    } t_item;

    typedef struct {
        logic        ok;
        logic [15:0] payload_offset;
        logic [3:0]  granted_level;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic        i_op;
    logic [15:0] i_req_bytes;
    logic [15:0] i_free_offset;
    logic        o_valid;
    logic        o_ok;
    logic [15:0] o_payload_offset;
    logic [3:0]  o_granted_level;

    buddy_block_allocator_unit dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_op             (i_op),
        .i_req_bytes      (i_req_bytes),
        .i_free_offset    (i_free_offset),
        .o_valid          (o_valid),
        .o_ok             (o_ok),
        .o_payload_offset (o_payload_offset),
        .o_granted_level  (o_granted_level)
    );

    t_item   pending_items[$];
    t_result expected_results[$];
    int      errors;
    bit      quiet_tail;

    // Allocator model state
    int  free_head[LEVELS];
    int  next_slot[SLOTS];
    int  prev_slot[SLOTS];
    int  blk_level[SLOTS];
    bit  blk_free[SLOTS];
    bit  blk_used[SLOTS];
    int  granted_offs[$];   // payload offsets currently held, for frees

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void model_reset();
        for (int i = 0; i < LEVELS; i++) free_head[i] = SLOT_NIL;
        for (int i = 0; i < SLOTS; i++) begin
            next_slot[i] = SLOT_NIL;
            prev_slot[i] = SLOT_NIL;
            blk_level[i] = 0;
            blk_free[i]  = 0;
            blk_used[i]  = 0;
        end
        free_head[0] = 0;
        blk_free[0]  = 1;
    endfunction

    function automatic void push_block(int lv, int s);
        int h;
        h = free_head[lv];
        next_slot[s] = h;
        prev_slot[s] = SLOT_NIL;
        if (h < SLOTS) prev_slot[h] = s;
        free_head[lv] = s;
        blk_free[s]   = 1;
        blk_level[s]  = lv;
    endfunction

    function automatic void unlink_block(int lv, int s);
        int p;
        int n;
        p = prev_slot[s];
        n = next_slot[s];
        if (p < SLOTS) next_slot[p] = n;
        else free_head[lv] = n;
        if (n < SLOTS) prev_slot[n] = p;
        next_slot[s] = SLOT_NIL;
        prev_slot[s] = SLOT_NIL;
        blk_free[s]  = 0;
    endfunction

    // Predict one command's result and advance the model
    function automatic t_result predict_alloc_free(t_item it);
        t_result r;
        int need, tgt, cur, s, lv, b, left, off;
        r = '{ok: 1'b0, payload_offset: 16'd0, granted_level: 4'd0};
        if (it.op == OP_ALLOC) begin
            need = 16 + ((int'(it.req_bytes) + 15) / 16) * 16;
            if (need > 65536) return r;
            tgt = 0;
            while (tgt + 1 < LEVELS && (65536 >> (tgt + 1)) >= need) tgt++;
            cur = tgt;
            while (cur >= 0 && free_head[cur] >= SLOTS) cur--;
            if (cur < 0) return r;
            while (cur < tgt) begin
                left = free_head[cur];
                unlink_block(cur, left);
                push_block(cur + 1, left + ((65536 >> (cur + 1)) / 32));
                push_block(cur + 1, left);
                cur++;
            end
            s = free_head[tgt];
            unlink_block(tgt, s);
            blk_used[s]  = 1;
            blk_level[s] = tgt;
            r.ok = 1'b1;
            r.payload_offset = 16'(s * 32 + 16);
            r.granted_level  = 4'(tgt);
            granted_offs.push_back(s * 32 + 16);
        end else begin
            off = int'(it.free_offset);
            if (off < 16 || (off - 16) % 32 != 0) return r;
            s = (off - 16) / 32;
            if (!blk_used[s]) return r;
            foreach (granted_offs[i])
                if (granted_offs[i] == off) begin
                    granted_offs.delete(i);
                    break;
                end
            lv = blk_level[s];
            blk_used[s] = 0;
            r.ok = 1'b1;
            r.granted_level = 4'(lv);
            push_block(lv, s);
            while (lv > 0) begin
                b = s ^ ((65536 >> lv) / 32);
                if (!blk_free[b] || blk_level[b] != lv) break;
                unlink_block(lv, b);
                unlink_block(lv, s);
                if (b < s) s = b;
                lv--;
                push_block(lv, s);
            end
        end
        return r;
    endfunction

    int gap_left;

    // Acceptance is tracked at the rising edge
    bit accepted;
    always @(posedge i_clk) begin
        t_item acc;
        accepted = i_rst_n && start && !busy;
        if (accepted) begin
            acc.op          = i_op;
            acc.req_bytes   = i_req_bytes;
            acc.free_offset = i_free_offset;
            acc.sync        = 1'b0;
            expected_results.push_back(predict_alloc_free(acc));
        end
    end

    // Driver: present the next item at the falling edge, random idle bursts
    always @(negedge i_clk) begin
        t_item it;
        if (i_rst_n) begin
            if (start && !accepted) begin
                // keep presenting until taken
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                start    <= 1'b0;
            end else if (pending_items.size() > 0 &&
                         !(pending_items[0].sync && expected_results.size() > 0)) begin
                if (!quiet_tail && $urandom_range(0, 9) == 0) begin
                    gap_left <= $urandom_range(1, 16) - 1;
                    start    <= 1'b0;
                end else begin
                    it = pending_items.pop_front();
                    start         <= 1'b1;
                    i_op          <= it.op;
                    i_req_bytes   <= it.req_bytes;
                    i_free_offset <= it.free_offset;
                end
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: compare each result strobe with the oldest expectation
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_ok !== e.ok) begin
                    $error("ok: expected %0d actual %0d", e.ok, o_ok);
                    errors++;
                end
                if (o_payload_offset !== e.payload_offset) begin
                    $error("payload_offset: expected %0d actual %0d",
                           e.payload_offset, o_payload_offset);
                    errors++;
                end
                if (o_granted_level !== e.granted_level) begin
                    $error("granted_level: expected %0d actual %0d",
                           e.granted_level, o_granted_level);
                    errors++;
                end
            end
        end
    end

    function automatic void add_item(logic op, int req, int offs, bit sync = 0);
        pending_items.push_back('{op: op, req_bytes: 16'(req),
                                  free_offset: 16'(offs), sync: sync});
    endfunction

    // Random request size: mostly small, sometimes large or random bits
    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 65535);
            1:       return $urandom_range(1000, 16000);
            default: return $urandom_range(0, 400);
        endcase
    endfunction

    // Stimulus
    initial begin
        int k, o;
        errors     = 0;
        quiet_tail = 0;
        model_reset();
        i_rst_n       = 1'b0;
        start         = 1'b0;
        i_op          = 1'b0;
        i_req_bytes   = 16'd0;
        i_free_offset = 16'd0;
        gap_left      = 0;
        // directed: extremes, whole space, too large, bad frees, double free
        add_item(OP_ALLOC, 65520, 0);            // whole space, level 0
        add_item(OP_ALLOC, 0, 0);                // no free block
        add_item(OP_FREE, 0, 16);                // free whole space
        add_item(OP_ALLOC, 65521, 0);            // too large
        add_item(OP_ALLOC, 65535, 0);
        add_item(OP_ALLOC, 0, 0);                // deepest level, full split
        add_item(OP_ALLOC, 16, 0);
        add_item(OP_ALLOC, 17, 0);
        add_item(OP_ALLOC, 32752, 0);
        add_item(OP_FREE, 0, 0);                 // below header
        add_item(OP_FREE, 0, 15);
        add_item(OP_FREE, 0, 24);                // misaligned
        add_item(OP_FREE, 0, 65535);
        add_item(OP_FREE, 0, 65520);             // never granted
        add_item(OP_FREE, 65535, 16);            // merge chain
        add_item(OP_FREE, 0, 16);                // double free
        add_item(OP_FREE, 0, 48);
        add_item(OP_FREE, 0, 80);
        add_item(OP_FREE, 0, 32784, 1);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk) i_rst_n = 1'b1;
        while (pending_items.size() != 0) @(posedge i_clk);
        // random: alloc/free mix over offsets tracked from the model
        for (int n = 0; n < 1100; n++) begin
            while (pending_items.size() >= 4 || expected_results.size() >= 4)
                @(posedge i_clk);
            if (n > 1000) quiet_tail = 1;
            k = $urandom_range(0, 99);
            if (k < 50) add_item(OP_ALLOC, pick_size(), $urandom_range(0, 65535));
            else if (k < 90 && granted_offs.size() > 0) begin
                while (pending_items.size() != 0 || expected_results.size() != 0)
                    @(posedge i_clk);
                o = granted_offs[$urandom_range(0, granted_offs.size() - 1)];
                add_item(OP_FREE, $urandom_range(0, 65535), o);
            end else if (k < 95)
                add_item(OP_FREE, $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
                add_item(OP_FREE, 0, $urandom_range(0, 2047) * 32 + 16);
            if (n == 500) pending_items[$].sync = 1;
        end
        while (pending_items.size() != 0 || start) @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/bba_pkg.sv
rtl/bba_ctrl.sv
rtl/bba_dp.sv
rtl/buddy_block_allocator_unit.sv
dv/tb.sv
